/* design/column_row_bit_interleaver_defines.svh */
// ----------------------------------------------------------------------------
// Column/row bit interleaver assertion macros
// Shared assertion forms for the interleaver RTL, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef COLUMN_ROW_BIT_INTERLEAVER_DEFINES_SVH
`define COLUMN_ROW_BIT_INTERLEAVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CRI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CRI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cri_pkg.sv */
// ----------------------------------------------------------------------------
// Column/row bit interleaver package
// Shared constants and codes for the interleaver modules.
// ----------------------------------------------------------------------------
package cri_pkg;

    localparam int DEF_MAX_FRAME_BITS = 65536;
    localparam int MAX_COLUMNS        = 5;

    localparam int SYM_W   = 5;
    localparam int MODE_W  = 2;
    localparam int BPS_W   = 3;
    localparam int ROWS_W  = 15;
    localparam int ORDER_W = 15;
    localparam int COL_W   = 3;
    localparam int NUM_FIELDS = ORDER_W / COL_W;
    localparam int CFG_AW  = 4;
    localparam int CFG_DW  = 32;

    localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAIR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COLUMN = 2'd3;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_BPS   = 2'd1;
    localparam logic [1:0] REG_ROWS  = 2'd2;
    localparam logic [1:0] REG_ORDER = 2'd3;

    localparam logic [MODE_W-1:0]  RST_MODE  = MODE_PAIR;
    localparam logic [BPS_W-1:0]   RST_BPS   = 3'd3;
    localparam logic [ROWS_W-1:0]  RST_ROWS  = 15'd21600;
    localparam logic [ORDER_W-1:0] RST_ORDER = 15'd0;

    localparam logic [BPS_W-1:0] MIN_COLS = 3'd3;
    localparam logic [BPS_W-1:0] MAX_COLS = BPS_W'(MAX_COLUMNS);

endpackage

/* design/column_row_bit_interleaver.sv */
// ----------------------------------------------------------------------------
// Column/row bit interleaver
// A pull reads n bits (1 to 5) one per cycle from the frame memory, then passes S_WAIT for the
// last registered read bit and S_OUT, which registers the result on m_valid; error pulls go
// straight to S_OUT. S_OUT holds while an earlier result still waits on m_ready, and no new item
// is taken until it has left. Synchronous active-low reset clears all control state.
// ----------------------------------------------------------------------------
`include "column_row_bit_interleaver_defines.svh"

module column_row_bit_interleaver #(
    parameter int MAX_FRAME_BITS = cri_pkg::DEF_MAX_FRAME_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cri_pkg::CFG_AW-1:0]  paddr,
    input  logic [cri_pkg::CFG_DW-1:0]  pwdata,
    output logic [cri_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic                        s_in_bit,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cri_pkg::SYM_W-1:0]   m_symbol,
    output logic                        m_last,
    output logic                        m_error
);

    import cri_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BITS);
    localparam int CW = AW + 2;
    localparam logic [CW-1:0] CAP1 = CW'(MAX_FRAME_BITS);
    localparam logic [CW-1:0] CAP2 = CW'(MAX_FRAME_BITS / 2);
    localparam logic [CW-1:0] CAP3 = CW'(MAX_FRAME_BITS / 3);
    localparam logic [CW-1:0] CAP4 = CW'(MAX_FRAME_BITS / 4);
    localparam logic [CW-1:0] CAP5 = CW'(MAX_FRAME_BITS / 5);
    localparam logic [CW-1:0] MAX_BITS = CW'(MAX_FRAME_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [BPS_W-1:0]    bps_reg;
    logic [ROWS_W-1:0]   rows_cfg_reg;
    logic [ORDER_W-1:0]  order_reg;
    logic [CW-1:0]       wcount_reg, wcount_next;
    logic [CW-1:0]       rcount_reg, rcount_next;
    logic                full_reg, full_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [2:0]          k_reg, k_next;
    logic [2:0]          nread_reg, nread_next;
    logic                pend_reg, pend_next;
    logic                mask_reg, mask_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic                last_res_reg, last_res_next;
    logic                err_res_reg, err_res_next;
    logic                m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]    m_symbol_reg, m_symbol_next;
    logic                m_last_reg, m_last_next;
    logic                m_error_reg, m_error_next;

    logic                cfg_wr;
    logic [1:0]          cfg_idx;
    logic [BPS_W-1:0]    ncol;
    logic [BPS_W-1:0]    bpr;
    logic [CW-1:0]       cap;
    logic [CW-1:0]       rows_raw;
    logic [CW-1:0]       rows;
    logic [CW-1:0]       length;
    logic [CW-1:0]       pulls;
    logic                s_acc;
    logic                push_wr;
    logic [COL_W-1:0]    perm [NUM_FIELDS];
    logic [COL_W-1:0]    col;
    logic                cur_mask;
    logic [CW-1:0]       mac_a;
    logic [2:0]          mac_b;
    logic [CW-1:0]       mac_c;
    logic [CW-1:0]       mac_p;
    logic [AW-1:0]       mem_addr;
    logic                mem_rdata;
    logic                out_free;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= RST_MODE;
            bps_reg      <= RST_BPS;
            rows_cfg_reg <= RST_ROWS;
            order_reg    <= RST_ORDER;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODE:  mode_reg     <= pwdata[MODE_W-1:0];
                REG_BPS:   bps_reg      <= pwdata[BPS_W-1:0];
                REG_ROWS:  rows_cfg_reg <= pwdata[ROWS_W-1:0];
                REG_ORDER: order_reg    <= pwdata[ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MODE:  prdata = CFG_DW'(mode_reg);
            REG_BPS:   prdata = CFG_DW'(bps_reg);
            REG_ROWS:  prdata = CFG_DW'(rows_cfg_reg);
            REG_ORDER: prdata = CFG_DW'(order_reg);
            default:   prdata = '0;
        endcase
    end

    // Frame geometry from the current registers.
    always_comb begin
        if (bps_reg < MIN_COLS) begin
            ncol = MIN_COLS;
        end else if (bps_reg > MAX_COLS) begin
            ncol = MAX_COLS;
        end else begin
            ncol = bps_reg;
        end
        case (mode_reg)
            MODE_COLUMN: bpr = ncol;
            MODE_PAIR:   bpr = 3'd2;
            default:     bpr = 3'd1;
        endcase
        case (bpr)
            3'd2:    cap = CAP2;
            3'd3:    cap = CAP3;
            3'd4:    cap = CAP4;
            3'd5:    cap = CAP5;
            default: cap = CAP1;
        endcase
        rows_raw = (rows_cfg_reg == '0) ? CW'(1) : CW'(rows_cfg_reg);
        rows     = (rows_raw > cap) ? cap : rows_raw;
        length   = CW'(rows * CW'(bpr));
        pulls    = (mode_reg == MODE_REPEAT) ? CW'({rows, 1'b0}) : rows;
    end

    always_comb begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
            perm[i] = order_reg[COL_W*i +: COL_W];
        end
    end

    assign col      = perm[k_reg];
    assign cur_mask = (mode_reg == MODE_COLUMN) && (col >= ncol);

    // Operands of the shared address unit for the current read step.
    always_comb begin
        case (mode_reg)
            MODE_REPEAT: begin
                mac_a = j_reg >> 1;
                mac_b = 3'd1;
                mac_c = '0;
            end
            MODE_PAIR: begin
                mac_a = j_reg;
                mac_b = 3'd2;
                mac_c = CW'(k_reg);
            end
            MODE_COLUMN: begin
                mac_a = rows;
                mac_b = col;
                mac_c = j_reg;
            end
            default: begin
                mac_a = j_reg;
                mac_b = 3'd1;
                mac_c = '0;
            end
        endcase
    end

    cri_mac #(
        .CW (CW)
    ) u_mac (
        .a (mac_a),
        .b (mac_b),
        .c (mac_c),
        .p (mac_p)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_acc    = s_valid & s_ready;
    assign push_wr  = s_acc && !s_func && !full_reg && (wcount_reg < length)
                      && (wcount_reg < MAX_BITS);
    assign mem_addr = (state_reg == S_READ) ? mac_p[AW-1:0] : wcount_reg[AW-1:0];

    cri_bit_mem #(
        .DEPTH (MAX_FRAME_BITS)
    ) u_mem (
        .aclk  (aclk),
        .we    (push_wr),
        .addr  (mem_addr),
        .wdata (s_in_bit),
        .rdata (mem_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        wcount_next   = wcount_reg;
        rcount_next   = rcount_reg;
        full_next     = full_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        nread_next    = nread_reg;
        pend_next     = pend_reg;
        mask_next     = mask_reg;
        sym_next      = sym_reg;
        last_res_next = last_res_reg;
        err_res_next  = err_res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_symbol_next = m_symbol_reg;
        m_last_next   = m_last_reg;
        m_error_next  = m_error_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_acc && !s_func) begin
                    if (!full_reg) begin
                        if (wcount_reg >= length) begin
                            full_next = 1'b1;
                        end else begin
                            wcount_next = wcount_reg + 1'b1;
                            if (CW'(wcount_reg + 1'b1) >= length) begin
                                full_next = 1'b1;
                            end
                        end
                    end
                end else if (s_acc) begin
                    sym_next  = '0;
                    pend_next = 1'b0;
                    k_next    = '0;
                    if (!full_reg) begin
                        last_res_next = 1'b0;
                        err_res_next  = 1'b1;
                        state_next    = S_OUT;
                    end else begin
                        err_res_next = 1'b0;
                        j_next = (rcount_reg >= pulls) ? CW'(pulls - 1'b1) : rcount_reg;
                        case (mode_reg)
                            MODE_PAIR:   nread_next = 3'd2;
                            MODE_COLUMN: nread_next = ncol;
                            default:     nread_next = 3'd1;
                        endcase
                        if (CW'(rcount_reg + 1'b1) >= pulls) begin
                            last_res_next = 1'b1;
                            wcount_next   = '0;
                            rcount_next   = '0;
                            full_next     = 1'b0;
                        end else begin
                            last_res_next = 1'b0;
                            rcount_next   = rcount_reg + 1'b1;
                        end
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                if (pend_reg) begin
                    sym_next = {sym_reg[SYM_W-2:0], mem_rdata & !mask_reg};
                end
                pend_next = 1'b1;
                mask_next = cur_mask;
                k_next    = k_reg + 1'b1;
                if (k_reg == nread_reg - 1'b1) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (pend_reg) begin
                    sym_next = {sym_reg[SYM_W-2:0], mem_rdata & !mask_reg};
                end
                pend_next  = 1'b0;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = sym_reg;
                    m_last_next   = last_res_reg;
                    m_error_next  = err_res_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wcount_reg  <= '0;
            rcount_reg  <= '0;
            full_reg    <= 1'b0;
            k_reg       <= '0;
            nread_reg   <= 3'd1;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wcount_reg  <= wcount_next;
            rcount_reg  <= rcount_next;
            full_reg    <= full_next;
            k_reg       <= k_next;
            nread_reg   <= nread_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        j_reg        <= j_next;
        mask_reg     <= mask_next;
        sym_reg      <= sym_next;
        last_res_reg <= last_res_next;
        err_res_reg  <= err_res_next;
        m_symbol_reg <= m_symbol_next;
        m_last_reg   <= m_last_next;
        m_error_reg  <= m_error_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_last   = m_last_reg;
    assign m_error  = m_error_reg;

    `CRI_ASSERT_NOW(a_full_has_bits, full_reg, wcount_reg != '0, "Full frame holds no bits.")
    `CRI_ASSERT_NOW(a_error_clean, m_valid_reg && m_error_reg,
        m_symbol_reg == '0 && !m_last_reg, "Error item carries symbol or last.")
    `CRI_ASSERT_NEXT(a_pull_reads, s_acc && s_func && full_reg, state_reg == S_READ,
        "Pull of a full frame did not start reading.")
    `CRI_ASSERT_NOW(a_step_range, state_reg == S_READ, k_reg < nread_reg,
        "Read step beyond the bits of one item.")
    `CRI_ASSERT_NOW(a_write_idle, push_wr, state_reg == S_IDLE,
        "Memory write outside the idle state.")

endmodule

/* design/cri_bit_mem.sv */
// ----------------------------------------------------------------------------
// Frame bit memory
// Single-ported one-bit-wide store with a registered read.
// ----------------------------------------------------------------------------
module cri_bit_mem #(
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     wdata,
    output logic                     rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/cri_mac.sv */
// ----------------------------------------------------------------------------
// Address multiply-add unit
// Shared unit that forms each read bit address as a * b + c.
// ----------------------------------------------------------------------------
module cri_mac #(
    parameter int CW = 18
) (
    input  logic [CW-1:0] a,
    input  logic [2:0]    b,
    input  logic [CW-1:0] c,
    output logic [CW-1:0] p
);

    logic [CW+2:0] prod;

    assign prod = ({3'b000, a} * {{CW{1'b0}}, b}) + {3'b000, c};
    assign p    = prod[CW-1:0];

endmodule
